@@ src/dhcp_client_lease_sequencer_top_assert.svh @@
// Assertion macros shared by the sequencer RTL.
`ifndef DHCP_CLIENT_LEASE_SEQUENCER_TOP_ASSERT_SVH
`define DHCP_CLIENT_LEASE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DCLS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcls: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define DCLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcls: next-cycle check failed");

`endif

@@ src/dcls_pkg.sv @@
`timescale 1ns / 1ps

package dcls_pkg;

  // Client phase
  typedef enum logic [2:0] {
    PH_INIT     = 3'd0,
    PH_DISCOVER = 3'd1,
    PH_REQUEST  = 3'd2,
    PH_BOUND    = 3'd3,
    PH_RENEWING = 3'd4
  } phase_t;

  // Input word kinds
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_REPLY = 1'b1;

  // Reply message types that count
  localparam logic [3:0] REPLY_OFFER = 4'd2;
  localparam logic [3:0] REPLY_ACK   = 4'd5;

  // Transmit message types
  localparam logic [1:0] MSG_NONE     = 2'd0;
  localparam logic [1:0] MSG_DISCOVER = 2'd1;
  localparam logic [1:0] MSG_REQUEST  = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAC_SERIAL       = 1'b1;

  localparam logic [9:0]  TPS_RESET  = 10'd100;
  localparam logic [15:0] LEASE_MIN  = 16'd60;
  localparam logic [31:0] LEASE_MAX  = 32'd43200;
  localparam logic [15:0] CNT_SAT    = 16'hFFFF;
  localparam logic [4:0]  JITTER_MASK = 5'h1f;

  typedef struct packed {
    logic        action;
    logic [3:0]  reply_type;
    logic [31:0] offered_ip;
    logic [31:0] lease_time;
    logic [31:0] server_ip;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [1:0]  tx_msg_type;
    logic        tx_unicast;
    logic        tx_with_server_id;
    logic [31:0] tx_xid;
    logic [31:0] tx_client_ip;
    logic [31:0] tx_requested_ip;
    logic [31:0] tx_server_ip;
    logic        address_ready;
    logic [31:0] current_ip;
  } out_item_t;

  // Sequencer state, kept in the top level and updated by the step logic
  typedef struct packed {
    phase_t      phase;
    logic [15:0] retry_count;
    logic [15:0] retry_interval;
    logic [15:0] base_interval;
    logic [15:0] subsecond_count;
    logic [15:0] seconds_count;
    logic [15:0] lease_seconds;
    logic [15:0] renew_seconds;
    logic [31:0] held_offer_ip;
    logic [31:0] held_server_ip;
    logic [31:0] assigned_ip;
    logic [31:0] transaction_id;
  } state_t;

  // Eight shifts of the 16-bit LFSR, taps 15, 14, 12 and 3
  function automatic logic [15:0] lfsr_step8(input logic [15:0] seed);
    logic [15:0] v;
    logic        fb;
    v = seed;
    for (int i = 0; i < 8; i++) begin
      fb = v[15] ^ v[14] ^ v[12] ^ v[3];
      v  = {v[14:0], fb};
    end
    return v;
  endfunction

  // Saturating increment of a 16-bit counter
  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == CNT_SAT) ? CNT_SAT : v + 16'd1;
  endfunction

endpackage

@@ src/dcls_step.sv @@
`timescale 1ns / 1ps

// One sequencer step: next state and result word from the current state
// and one input word.
module dcls_step (
  input  dcls_pkg::state_t    state,
  input  dcls_pkg::in_item_t  item,
  input  logic [9:0]          ticks_per_second,
  input  logic [15:0]         mac_serial,
  output dcls_pkg::state_t    state_next,
  output dcls_pkg::out_item_t result
);

  logic [15:0] rc_inc;
  logic [15:0] sc_inc;
  logic [15:0] retry_cap;
  logic [16:0] doubled;
  logic [15:0] sec_inc;
  logic [15:0] lease_clamp;
  logic [15:0] base_new;
  logic [15:0] lfsr_val;
  logic [15:0] jitter;
  logic        running;
  logic        tx_fire;
  logic        sec_fire;

  // Tick arithmetic
  always_comb begin
    rc_inc    = dcls_pkg::sat_inc(state.retry_count);
    sc_inc    = dcls_pkg::sat_inc(state.subsecond_count);
    // 60 * tps = 64 * tps - 4 * tps, fits in 16 bits
    retry_cap = {ticks_per_second, 6'd0} - {4'd0, ticks_per_second, 2'd0};
    doubled   = {state.retry_interval, 1'b0};
    sec_inc   = state.seconds_count + 16'd1;
    lfsr_val  = dcls_pkg::lfsr_step8(mac_serial);
    jitter    = {11'd0, lfsr_val[4:0] & dcls_pkg::JITTER_MASK};
    base_new  = {6'd0, ticks_per_second} + jitter;
    running   = (state.phase == dcls_pkg::PH_DISCOVER) ||
                (state.phase == dcls_pkg::PH_REQUEST) ||
                (state.phase == dcls_pkg::PH_BOUND) ||
                (state.phase == dcls_pkg::PH_RENEWING);
    tx_fire   = (item.action == dcls_pkg::ACT_TICK) && running &&
                (state.phase != dcls_pkg::PH_BOUND) && (rc_inc >= state.retry_interval);
    sec_fire  = (item.action == dcls_pkg::ACT_TICK) &&
                ((state.phase == dcls_pkg::PH_BOUND) ||
                 (state.phase == dcls_pkg::PH_RENEWING)) &&
                (sc_inc >= {6'd0, ticks_per_second});
  end

  // Lease clamp to 60..43200 seconds
  always_comb begin
    if (item.lease_time < dcls_pkg::LEASE_MAX) begin
      lease_clamp = item.lease_time[15:0];
    end else begin
      lease_clamp = dcls_pkg::LEASE_MAX[15:0];
    end
    if (lease_clamp < dcls_pkg::LEASE_MIN) begin
      lease_clamp = dcls_pkg::LEASE_MIN;
    end
  end

  // State update
  always_comb begin
    state_next = state;
    if (item.action == dcls_pkg::ACT_TICK) begin
      if (running) begin
        state_next.retry_count     = rc_inc;
        state_next.subsecond_count = sc_inc;
        if (tx_fire) begin
          state_next.retry_count = 16'd0;
          if (state.retry_interval < retry_cap) begin
            state_next.retry_interval = doubled[16] ? dcls_pkg::CNT_SAT : doubled[15:0];
          end
        end
        if (sec_fire) begin
          state_next.subsecond_count = 16'd0;
          state_next.seconds_count   = sec_inc;
          if (sec_inc == state.renew_seconds) begin
            state_next.retry_interval = state.base_interval;
            state_next.phase          = dcls_pkg::PH_RENEWING;
          end else if (sec_inc >= state.lease_seconds) begin
            state_next.phase = dcls_pkg::PH_INIT;
          end
        end
      end else begin
        // init (or an unused code): start discovery
        state_next.assigned_ip     = 32'd0;
        state_next.seconds_count   = 16'd0;
        state_next.retry_count     = 16'd0;
        state_next.subsecond_count = 16'd0;
        state_next.base_interval   = base_new;
        state_next.retry_interval  = base_new;
        state_next.transaction_id  = {base_new, mac_serial};
        state_next.phase           = dcls_pkg::PH_DISCOVER;
      end
    end else begin
      if ((state.phase == dcls_pkg::PH_DISCOVER) &&
          (item.reply_type == dcls_pkg::REPLY_OFFER)) begin
        state_next.held_server_ip = item.server_ip;
        state_next.held_offer_ip  = item.offered_ip;
        state_next.retry_interval = state.base_interval;
        state_next.phase          = dcls_pkg::PH_REQUEST;
      end else if (((state.phase == dcls_pkg::PH_REQUEST) ||
                    (state.phase == dcls_pkg::PH_RENEWING)) &&
                   (item.reply_type == dcls_pkg::REPLY_ACK)) begin
        state_next.lease_seconds = lease_clamp;
        state_next.renew_seconds = {1'b0, lease_clamp[15:1]};
        state_next.seconds_count = 16'd0;
        state_next.assigned_ip   = state.held_offer_ip;
        state_next.phase         = dcls_pkg::PH_BOUND;
      end
    end
  end

  // Result word; transmit fields read as zero when nothing is sent
  always_comb begin
    result = '0;
    if (tx_fire) begin
      result.tx_valid          = 1'b1;
      result.tx_msg_type       = (state.phase == dcls_pkg::PH_DISCOVER) ?
                                 dcls_pkg::MSG_DISCOVER : dcls_pkg::MSG_REQUEST;
      result.tx_unicast        = (state.phase == dcls_pkg::PH_RENEWING);
      result.tx_with_server_id = (state.phase == dcls_pkg::PH_REQUEST);
      result.tx_xid            = state.transaction_id;
      result.tx_client_ip      = state.assigned_ip;
      result.tx_requested_ip   = state.held_offer_ip;
      result.tx_server_ip      = state.held_server_ip;
    end else begin
      result.tx_msg_type = dcls_pkg::MSG_NONE;
    end
    result.address_ready = (state_next.phase == dcls_pkg::PH_BOUND) ||
                           (state_next.phase == dcls_pkg::PH_RENEWING);
    result.current_ip    = state_next.assigned_ip;
  end

endmodule

@@ src/dhcp_client_lease_sequencer_top.sv @@
`timescale 1ns / 1ps

// DHCP client lease sequencer.
// Input channel (in_valid / in_stall / in_data): one word per timer tick or
// per parsed DHCP reply. Output channel (out_valid / out_stall / out_data):
// exactly one result word per input word, in order, carrying any transmit
// request and the bound address.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// index 0 ticks_per_second, index 1 mac_serial; always ready, write only
// while no words are in flight.
// A word accepted into the input register goes through one pass of step
// logic into the result register.
// Throughput: one word per cycle unless out_stall holds the result register;
// combinational step logic reads and updates the state register.
// Reset (rst, synchronous): phase init, all counters and addresses zero,
// ticks_per_second 100, mac_serial 0, both channels empty.
// When out_stall holds the full result register, the input register keeps
// its word and in_stall rises; nothing is lost or repeated.
module dhcp_client_lease_sequencer_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  dcls_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output dcls_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dcls_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data
);

  logic                 in_q_valid;
  dcls_pkg::in_item_t   in_q;
  dcls_pkg::state_t     state;
  dcls_pkg::state_t     state_next;
  dcls_pkg::out_item_t  result;
  logic [9:0]           ticks_per_second;
  logic [15:0]          mac_serial;
  logic                 advance;
  logic                 renew_tx;

  assign cfg_ready = 1'b1;
  assign advance   = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && out_valid && out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= dcls_pkg::TPS_RESET;
      mac_serial       <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dcls_pkg::REG_TICKS_PER_SECOND: ticks_per_second <= cfg_data[9:0];
        dcls_pkg::REG_MAC_SERIAL:       mac_serial       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  dcls_step u_step (
    .state            (state),
    .item             (in_q),
    .ticks_per_second (ticks_per_second),
    .mac_serial       (mac_serial),
    .state_next       (state_next),
    .result           (result)
  );

  // Sequencer state; phase init is code zero
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // A transmit while the address is usable only happens when renewing
  assign renew_tx = out_valid && out_data.tx_valid && out_data.address_ready;

`include "dhcp_client_lease_sequencer_top_assert.svh"

  `DCLS_ASSERT_IMPLIES(a_stall_needs_word, clk, rst, in_stall, in_q_valid && out_valid)
  `DCLS_ASSERT_NEXT(a_advance_fills_out, clk, rst, advance, out_valid)
  `DCLS_ASSERT_IMPLIES(a_renew_unicast, clk, rst, renew_tx, out_data.tx_unicast)

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_PCT    = 19;
  localparam int QUIET_LIMIT = 1000;
  localparam int SHOW_MAX    = 10;

  // One row of the directed table
  typedef struct {
    dcls_pkg::in_item_t  word;
    bit                  typed;
    dcls_pkg::out_item_t want;
  } dir_row_t;

  // Client state as the predictor keeps it
  typedef struct packed {
    dcls_pkg::phase_t ph;
    logic [15:0]      since_tx;
    logic [15:0]      retry_gap;
    logic [15:0]      base_gap;
    logic [15:0]      tick_in_sec;
    logic [15:0]      secs;
    logic [15:0]      lease_len;
    logic [15:0]      renew_at;
    logic [31:0]      offer_ip;
    logic [31:0]      server_ip;
    logic [31:0]      my_ip;
    logic [31:0]      xid;
  } lease_state_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  dcls_pkg::in_item_t             in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  dcls_pkg::out_item_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [dcls_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                    cfg_data = '0;

  lease_state_t        cl;
  logic [9:0]          cl_tps;
  logic [15:0]         cl_serial;
  dcls_pkg::out_item_t due_words[$];
  dir_row_t            directed_rows[$];

  bit                  no_gaps = 1'b0;
  bit                  row_typed = 1'b0;
  dcls_pkg::out_item_t row_want = '0;

  int quiet_cycles = 0;
  int mismatches = 0;
  int words_checked = 0;
  int sent_discover = 0, sent_request = 0, sent_renew = 0;
  int binds = 0, renewals = 0, expiries = 0;
  int settings_used = 0;

  dhcp_client_lease_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Jitter: eight shifts of the serial through the 16-bit LFSR, low five bits kept
  function automatic logic [4:0] serial_jitter(logic [15:0] seed);
    logic [15:0] r;
    r = seed;
    repeat (8) r = {r[14:0], ^(r & 16'hD008)};
    return r[4:0];
  endfunction

  // Advance the predicted client by one word and return the result it gives
  function automatic dcls_pkg::out_item_t advance_client(dcls_pkg::in_item_t w);
    dcls_pkg::out_item_t r;
    logic [16:0]         dbl;
    logic [31:0]         ls;
    int unsigned         cap;
    r = '0;
    if (w.action == dcls_pkg::ACT_TICK) begin
      if (cl.ph == dcls_pkg::PH_INIT) begin
        // start discovery, nothing goes out on this tick
        cl.my_ip       = '0;
        cl.secs        = '0;
        cl.since_tx    = '0;
        cl.tick_in_sec = '0;
        cl.base_gap    = 16'(cl_tps) + 16'(serial_jitter(cl_serial));
        cl.retry_gap   = cl.base_gap;
        cl.xid         = {cl.base_gap, cl_serial};
        cl.ph          = dcls_pkg::PH_DISCOVER;
      end else begin
        if (cl.since_tx != 16'hFFFF) cl.since_tx++;
        if (cl.tick_in_sec != 16'hFFFF) cl.tick_in_sec++;
        // retransmit timer
        if (cl.ph != dcls_pkg::PH_BOUND && cl.since_tx >= cl.retry_gap) begin
          cap = 60 * cl_tps;
          cl.since_tx = '0;
          r.tx_valid          = 1'b1;
          r.tx_msg_type       = (cl.ph == dcls_pkg::PH_DISCOVER) ?
                                dcls_pkg::MSG_DISCOVER : dcls_pkg::MSG_REQUEST;
          r.tx_unicast        = (cl.ph == dcls_pkg::PH_RENEWING);
          r.tx_with_server_id = (cl.ph == dcls_pkg::PH_REQUEST);
          r.tx_xid            = cl.xid;
          r.tx_client_ip      = cl.my_ip;
          r.tx_requested_ip   = cl.offer_ip;
          r.tx_server_ip      = cl.server_ip;
          if (cl.retry_gap < cap) begin
            dbl = {cl.retry_gap, 1'b0};
            cl.retry_gap = dbl[16] ? 16'hFFFF : dbl[15:0];
          end
          case (cl.ph)
            dcls_pkg::PH_DISCOVER: sent_discover++;
            dcls_pkg::PH_REQUEST:  sent_request++;
            default:               sent_renew++;
          endcase
        end
        // lease clock
        if ((cl.ph == dcls_pkg::PH_BOUND || cl.ph == dcls_pkg::PH_RENEWING) &&
            cl.tick_in_sec >= 16'(cl_tps)) begin
          cl.tick_in_sec = '0;
          cl.secs = cl.secs + 16'd1;
          if (cl.secs == cl.renew_at) begin
            cl.retry_gap = cl.base_gap;
            if (cl.ph == dcls_pkg::PH_BOUND) renewals++;
            cl.ph = dcls_pkg::PH_RENEWING;
          end else if (cl.secs >= cl.lease_len) begin
            cl.ph = dcls_pkg::PH_INIT;
            expiries++;
          end
        end
      end
    end else if (cl.ph == dcls_pkg::PH_DISCOVER && w.reply_type == dcls_pkg::REPLY_OFFER) begin
      cl.server_ip = w.server_ip;
      cl.offer_ip  = w.offered_ip;
      cl.retry_gap = cl.base_gap;
      cl.ph        = dcls_pkg::PH_REQUEST;
    end else if ((cl.ph == dcls_pkg::PH_REQUEST || cl.ph == dcls_pkg::PH_RENEWING) &&
                 w.reply_type == dcls_pkg::REPLY_ACK) begin
      // clamp the lease, renew at half of it
      ls = (w.lease_time < dcls_pkg::LEASE_MAX) ? w.lease_time : dcls_pkg::LEASE_MAX;
      if (ls < 32'(dcls_pkg::LEASE_MIN)) ls = 32'(dcls_pkg::LEASE_MIN);
      cl.lease_len = ls[15:0];
      cl.renew_at  = ls[16:1];
      cl.secs      = '0;
      cl.my_ip     = cl.offer_ip;
      cl.ph        = dcls_pkg::PH_BOUND;
      binds++;
    end
    r.address_ready = (cl.ph == dcls_pkg::PH_BOUND || cl.ph == dcls_pkg::PH_RENEWING);
    r.current_ip    = cl.my_ip;
    return r;
  endfunction

  task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= SHOW_MAX)
        $display("word %0d %s: expected %h actual %h", words_checked, name, want, got);
    end
  endtask

  // Predict on accepted inputs, check accepted results, follow register writes
  always @(posedge clk) begin
    dcls_pkg::out_item_t predicted, want;
    if (rst) begin
      cl = '0;
      cl.ph = dcls_pkg::PH_INIT;
      cl_tps = dcls_pkg::TPS_RESET;
      cl_serial = '0;
      due_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dcls_pkg::REG_TICKS_PER_SECOND) cl_tps = cfg_data[9:0];
        else cl_serial = cfg_data[15:0];
      end
      if (in_valid && !in_stall) begin
        predicted = advance_client(in_data);
        due_words.push_back(row_typed ? row_want : predicted);
      end
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_MAX) $display("result word with none expected: %h", out_data);
        end else begin
          want = due_words.pop_front();
          note_field("tx_valid", 32'(want.tx_valid), 32'(out_data.tx_valid));
          note_field("tx_msg_type", 32'(want.tx_msg_type), 32'(out_data.tx_msg_type));
          note_field("tx_unicast", 32'(want.tx_unicast), 32'(out_data.tx_unicast));
          note_field("tx_with_server_id", 32'(want.tx_with_server_id),
                     32'(out_data.tx_with_server_id));
          note_field("tx_xid", want.tx_xid, out_data.tx_xid);
          note_field("tx_client_ip", want.tx_client_ip, out_data.tx_client_ip);
          note_field("tx_requested_ip", want.tx_requested_ip, out_data.tx_requested_ip);
          note_field("tx_server_ip", want.tx_server_ip, out_data.tx_server_ip);
          note_field("address_ready", 32'(want.address_ready), 32'(out_data.address_ready));
          note_field("current_ip", want.current_ip, out_data.current_ip);
          words_checked++;
        end
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("no handshake for %0d cycles, %0d words outstanding", quiet_cycles,
               due_words.size());
      $display("dhcp_client_lease_sequencer_top regression: fail");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk)
    out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);

  function automatic logic [31:0] short_lease();
    case ($urandom_range(3))
      0:       return $urandom_range(59);
      1:       return 32'd59 + $urandom_range(2);   // either side of the floor
      default: return $urandom_range(200, 62);
    endcase
  endfunction

  // Mostly well-formed exchanges steered by the predicted phase, some noise
  function automatic dcls_pkg::in_item_t next_stimulus(int reply_pct, bit soak);
    dcls_pkg::in_item_t w;
    int                 roll;
    w.action     = dcls_pkg::ACT_TICK;
    w.reply_type = 4'($urandom_range(15));
    w.offered_ip = $urandom;
    w.lease_time = $urandom;
    w.server_ip  = $urandom;
    roll = $urandom_range(99);
    if (!soak && roll < 10) begin
      w.action     = 1'($urandom_range(1));
      w.lease_time = short_lease();
    end else if (roll < 10 + reply_pct) begin
      case (cl.ph)
        dcls_pkg::PH_DISCOVER: begin
          w.action     = dcls_pkg::ACT_REPLY;
          w.reply_type = dcls_pkg::REPLY_OFFER;
        end
        dcls_pkg::PH_REQUEST, dcls_pkg::PH_RENEWING: begin
          if (!soak || cl.ph == dcls_pkg::PH_REQUEST) begin
            w.action     = dcls_pkg::ACT_REPLY;
            w.reply_type = dcls_pkg::REPLY_ACK;
            if (!soak) w.lease_time = short_lease();
            else begin
              // leases at or above the ceiling
              case ($urandom_range(3))
                0:       w.lease_time = dcls_pkg::LEASE_MAX;
                1:       w.lease_time = dcls_pkg::LEASE_MAX + 32'd1;
                2:       w.lease_time = 32'hFFFF_FFFF;
                default: w.lease_time = $urandom | 32'h8000_0000;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
    return w;
  endfunction

  // Called at a falling edge; returns at the rising edge that takes the word
  task automatic drive_word(dcls_pkg::in_item_t w, bit typed, dcls_pkg::out_item_t want);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= w;
    row_typed = typed;
    row_want  = want;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic write_reg(logic [dcls_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
  endtask

  // Drain, then write both registers; unused upper data bits carry junk
  task automatic set_config(logic [9:0] tps, logic [15:0] serial);
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(negedge clk);
    write_reg(dcls_pkg::REG_TICKS_PER_SECOND, {22'($urandom), tps});
    write_reg(dcls_pkg::REG_MAC_SERIAL, {16'($urandom), serial});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(logic [9:0] tps, logic [15:0] serial, int words, int reply_pct,
                           bit gapless);
    set_config(tps, serial);
    no_gaps = gapless;
    for (int n = 0; n < words; n++) begin
      @(negedge clk);
      drive_word(next_stimulus(reply_pct, 1'b0), 1'b0, '0);
    end
    no_gaps = 1'b0;
  endtask

  task automatic add_row(logic act, logic [3:0] kind, logic [31:0] offer, logic [31:0] lease,
                         logic [31:0] server, bit typed, dcls_pkg::out_item_t want);
    dir_row_t r;
    r.word  = {act, kind, offer, lease, server};
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endtask

  initial begin
    dcls_pkg::out_item_t bound_word;
    bit                  soak_bound;
    int                  soak_left;

    bound_word = '0;
    bound_word.address_ready = 1'b1;
    bound_word.current_ip    = 32'hFFFF_FFFF;

    // Directed walk: replies out of place, init tick, offer, ack with a zero lease
    add_row(dcls_pkg::ACT_REPLY, dcls_pkg::REPLY_OFFER, '1, '1, '1, 1'b1, '0);
    add_row(dcls_pkg::ACT_REPLY, dcls_pkg::REPLY_ACK, '1, '1, '1, 1'b1, '0);
    add_row(dcls_pkg::ACT_REPLY, 4'hF, '1, '1, '1, 1'b1, '0);
    add_row(dcls_pkg::ACT_REPLY, 4'h0, '0, '0, '0, 1'b1, '0);
    add_row(dcls_pkg::ACT_TICK, 4'hF, '1, '1, '1, 1'b1, '0);
    add_row(dcls_pkg::ACT_TICK, 4'h0, '0, '0, '0, 1'b0, '0);
    add_row(dcls_pkg::ACT_REPLY, dcls_pkg::REPLY_ACK, '1, '1, '1, 1'b0, '0);
    add_row(dcls_pkg::ACT_TICK, dcls_pkg::REPLY_OFFER, '0, '0, '0, 1'b0, '0);
    add_row(dcls_pkg::ACT_REPLY, dcls_pkg::REPLY_OFFER, '1, '0, '0, 1'b0, '0);
    add_row(dcls_pkg::ACT_REPLY, dcls_pkg::REPLY_OFFER, '0, '1, '1, 1'b0, '0);
    add_row(dcls_pkg::ACT_TICK, dcls_pkg::REPLY_ACK, '0, '0, '0, 1'b0, '0);
    add_row(dcls_pkg::ACT_TICK, 4'h0, '1, '1, '1, 1'b0, '0);
    add_row(dcls_pkg::ACT_REPLY, dcls_pkg::REPLY_ACK, '0, '0, '0, 1'b1, bound_word);
    add_row(dcls_pkg::ACT_REPLY, dcls_pkg::REPLY_ACK, '0, '1, '0, 1'b0, '0);
    add_row(dcls_pkg::ACT_REPLY, dcls_pkg::REPLY_OFFER, '0, '0, '1, 1'b0, '0);
    add_row(dcls_pkg::ACT_TICK, 4'h0, '0, '0, '0, 1'b0, '0);
    add_row(dcls_pkg::ACT_TICK, 4'h0, '0, '0, '0, 1'b0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero tick rate makes every tick a lease second
    set_config(10'd0, 16'hFFFF);
    foreach (directed_rows[i]) begin
      @(negedge clk);
      drive_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases over a range of tick rates and serials
    run_phase(10'd1, 16'($urandom), 300, 1, 1'b0);
    run_phase(10'd0, 16'h0000, 300, 25, 1'b1);
    run_phase(10'd2, 16'hFFFF, 300, 6, 1'b0);
    run_phase(10'd546, 16'($urandom), 100, 15, 1'b0);
    run_phase(10'd408, 16'($urandom), 80, 15, 1'b0);
    run_phase(10'd100, 16'($urandom), 120, 15, 1'b0);
    run_phase(10'd3, 16'($urandom), 200, 8, 1'b0);
    run_phase(10'd1, 16'($urandom), 200, 15, 1'b0);

    // Long lease soak: bind at the ceiling, then ride the lease clock for a while
    set_config(10'd0, 16'($urandom));
    soak_bound = 1'b0;
    soak_left  = 80;
    for (int n = 0; n < 600 && soak_left > 0; n++) begin
      @(negedge clk);
      if (cl.ph == dcls_pkg::PH_BOUND && cl.lease_len == 16'(dcls_pkg::LEASE_MAX))
        soak_bound = 1'b1;
      if (soak_bound) soak_left--;
      drive_word(next_stimulus(40, 1'b1), 1'b0, '0);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (due_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (due_words.size() != 0) begin
      mismatches++;
      $display("%0d expected words never arrived", due_words.size());
    end

    $display("checked %0d words over %0d register settings", words_checked, settings_used);
    $display("sent %0d discover, %0d request, %0d renew; bound %0d, renewed %0d, expired %0d",
             sent_discover, sent_request, sent_renew, binds, renewals, expiries);
    if (mismatches == 0)
      $display("dhcp_client_lease_sequencer_top regression: pass");
    else
      $display("dhcp_client_lease_sequencer_top regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/dcls_pkg.sv
src/dcls_step.sv
src/dhcp_client_lease_sequencer_top.sv
bench/tb_top.sv
